// ----- sv/srsc_pkg.sv -----
// ---------------------------------------------------------------------------
// srsc_pkg
// Shared constants, op codes and payload types of the sample rate setting
// controller.
// ---------------------------------------------------------------------------
`default_nettype none

package srsc_pkg;

	localparam int PHASE_MODULUS = 20;
	localparam int BLINK_PERIOD  = 10;
	localparam int MAX_RATE      = 10;

	localparam int OP_W     = 3;
	localparam int STORED_W = 8;
	localparam int RATE_W   = 4;	// width of the rate field on the result channel

	// internal widths follow from the constants
	localparam int RATE_INT_W = $clog2(MAX_RATE + 1);
	localparam int PHASE_W    = $clog2(PHASE_MODULUS);
	localparam int PHASE_SUM_W =
		(PHASE_W > RATE_INT_W ? PHASE_W : RATE_INT_W) + 1;
	localparam int BLINK_W    = $clog2(BLINK_PERIOD + 1);

	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_SET     = 3'd1;
	localparam logic [OP_W-1:0] OP_UP      = 3'd2;
	localparam logic [OP_W-1:0] OP_DOWN    = 3'd3;
	localparam logic [OP_W-1:0] OP_SAMPLED = 3'd4;
	localparam logic [OP_W-1:0] OP_RESTORE = 3'd5;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              setting_mode;
		logic              digit_blank;
		logic              sample_due;
		logic              save_request;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/srsc_if.sv -----
// ---------------------------------------------------------------------------
// srsc_if
// Valid/ready channels of the sample rate setting controller: the event
// channel in and the status channel out.
// ---------------------------------------------------------------------------
`default_nettype none

interface srsc_evt_if;
	logic                          valid;
	logic                          ready;
	logic [srsc_pkg::OP_W-1:0]     op;
	logic [srsc_pkg::STORED_W-1:0] stored_rate;

	modport source (output valid, output op, output stored_rate, input ready);
	modport sink   (input valid, input op, input stored_rate, output ready);
endinterface

interface srsc_res_if;
	logic                        valid;
	logic                        ready;
	logic [srsc_pkg::RATE_W-1:0] rate;
	logic                        setting_mode;
	logic                        digit_blank;
	logic                        sample_due;
	logic                        save_request;

	modport source (output valid, output rate, output setting_mode, output digit_blank,
		output sample_due, output save_request, input ready);
	modport sink   (input valid, input rate, input setting_mode, input digit_blank,
		input sample_due, input save_request, output ready);
endinterface

`default_nettype wire

// ----- sv/sample_rate_setting_controller.sv -----
// ---------------------------------------------------------------------------
// sample_rate_setting_controller
// Event-driven rate setting: mode flag, rate, sampling phase and digit blink.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+----------
//  evt     | in  | op, stored_rate                                 | valid/ready
//  res     | out | rate, setting_mode, digit_blank, sample_due,    | valid/ready
//          |     | save_request                                    |
//
//  One event per cycle; its status is registered in the cycle after it.
//  The state update is a single pass of small adders and compares.
//  evt.ready is high whenever the result register is empty or being taken,
//  so a stalled result holds back only the next event.
//  Reset (arst_n low) restores rate 1, ready flag set, normal mode.
// ---------------------------------------------------------------------------
`default_nettype none

module sample_rate_setting_controller (
	input  wire         clk,
	input  wire         arst_n,
	srsc_evt_if.sink    evt,
	srsc_res_if.source  res
);

	logic                                mode_q, mode_d;
	logic [srsc_pkg::RATE_INT_W-1:0]     rate_q, rate_d;
	logic [srsc_pkg::PHASE_W-1:0]        phase_q, phase_d;
	logic [srsc_pkg::BLINK_W-1:0]        blink_q, blink_d;
	logic                                visible_q, visible_d;
	logic                                rdy_q, rdy_d;
	logic                                save_d;

	logic [srsc_pkg::PHASE_SUM_W-1:0]    phase_sum;
	logic [srsc_pkg::BLINK_W-1:0]        blink_inc;
	logic                                stored_ok;

	srsc_pkg::res_t                      res_q, res_d;
	logic                                res_valid_q;
	logic                                evt_fire;

	assign evt.ready = !res_valid_q || res.ready;
	assign evt_fire  = evt.valid && evt.ready;

	assign phase_sum = srsc_pkg::PHASE_SUM_W'(phase_q) + srsc_pkg::PHASE_SUM_W'(rate_q);
	assign blink_inc = blink_q + srsc_pkg::BLINK_W'(1);
	assign stored_ok = (evt.stored_rate != '0) &&
		(evt.stored_rate <= srsc_pkg::STORED_W'(srsc_pkg::MAX_RATE));

	always_comb begin
		mode_d    = mode_q;
		rate_d    = rate_q;
		phase_d   = phase_q;
		blink_d   = blink_q;
		visible_d = visible_q;
		rdy_d     = rdy_q;
		save_d    = 1'b0;
		case (evt.op)
			srsc_pkg::OP_TICK: begin
				if (mode_q) begin
					if (blink_inc >= srsc_pkg::BLINK_W'(srsc_pkg::BLINK_PERIOD)) begin
						blink_d   = '0;
						visible_d = !visible_q;
					end else begin
						blink_d = blink_inc;
					end
				end else begin
					visible_d = 1'b1;
					blink_d   = '0;
					if (phase_sum >= srsc_pkg::PHASE_SUM_W'(srsc_pkg::PHASE_MODULUS)) begin
						phase_d = srsc_pkg::PHASE_W'(phase_sum -
							srsc_pkg::PHASE_SUM_W'(srsc_pkg::PHASE_MODULUS));
						rdy_d   = 1'b1;
					end else begin
						phase_d = srsc_pkg::PHASE_W'(phase_sum);
					end
				end
			end
			srsc_pkg::OP_SET: begin
				mode_d    = !mode_q;
				visible_d = 1'b1;
				blink_d   = '0;
			end
			srsc_pkg::OP_UP: begin
				if (mode_q) begin
					if (rate_q >= srsc_pkg::RATE_INT_W'(srsc_pkg::MAX_RATE))
						rate_d = srsc_pkg::RATE_INT_W'(1);
					else
						rate_d = rate_q + srsc_pkg::RATE_INT_W'(1);
					visible_d = 1'b1;
					blink_d   = '0;
					save_d    = 1'b1;
				end
			end
			srsc_pkg::OP_DOWN: begin
				if (mode_q) begin
					if (rate_q <= srsc_pkg::RATE_INT_W'(1))
						rate_d = srsc_pkg::RATE_INT_W'(srsc_pkg::MAX_RATE);
					else
						rate_d = rate_q - srsc_pkg::RATE_INT_W'(1);
					visible_d = 1'b1;
					blink_d   = '0;
					save_d    = 1'b1;
				end
			end
			srsc_pkg::OP_SAMPLED: begin
				if (!mode_q)
					rdy_d = 1'b0;
			end
			srsc_pkg::OP_RESTORE: begin
				if (stored_ok) begin
					rate_d = srsc_pkg::RATE_INT_W'(evt.stored_rate);
				end else begin
					rate_d = srsc_pkg::RATE_INT_W'(1);
					save_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d.rate         = srsc_pkg::RATE_W'(rate_d);
		res_d.setting_mode = mode_d;
		res_d.digit_blank  = mode_d && !visible_d;
		res_d.sample_due   = rdy_d;
		res_d.save_request = save_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			rate_q      <= srsc_pkg::RATE_INT_W'(1);
			phase_q     <= '0;
			blink_q     <= '0;
			visible_q   <= 1'b1;
			rdy_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (evt_fire) begin
				mode_q    <= mode_d;
				rate_q    <= rate_d;
				phase_q   <= phase_d;
				blink_q   <= blink_d;
				visible_q <= visible_d;
				rdy_q     <= rdy_d;
			end
			if (evt_fire)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (evt_fire)
			res_q <= res_d;
	end

	assign res.valid        = res_valid_q;
	assign res.rate         = res_q.rate;
	assign res.setting_mode = res_q.setting_mode;
	assign res.digit_blank  = res_q.digit_blank;
	assign res.sample_due   = res_q.sample_due;
	assign res.save_request = res_q.save_request;

`ifndef SYNTH
	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rate_q != '0) && (rate_q <= srsc_pkg::RATE_INT_W'(srsc_pkg::MAX_RATE)))
		else $error("rate out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < srsc_pkg::PHASE_W'(srsc_pkg::PHASE_MODULUS))
		else $error("phase out of range");

	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q < srsc_pkg::BLINK_W'(srsc_pkg::BLINK_PERIOD))
		else $error("blink count out of range");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		evt_fire |=> (res_valid_q && res_q.setting_mode == mode_q &&
			res_q.sample_due == rdy_q))
		else $error("result does not match state after transaction");

	a_blank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.digit_blank |-> res.setting_mode)
		else $error("digit blanked outside setting mode");
`endif

endmodule

`default_nettype wire
